[rtl/client_table_lru_with_aging_assert.svh]
// Assertion macros shared by the client table RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef CLIENT_TABLE_LRU_WITH_AGING_ASSERT_SVH
`define CLIENT_TABLE_LRU_WITH_AGING_ASSERT_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define CTLRU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("client table assertion failed");
// The condition must never be true outside reset.
`define CTLRU_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("client table forbidden condition seen");
`else
`define CTLRU_ASSERT(lbl, clk, rst, prop)
`define CTLRU_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

[rtl/ctlru_pkg.sv]
// Shared types and constants for the client table with LRU replacement and aging.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctlru_pkg;

   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int TIME_W    = 32;
   localparam int ACTION_W  = 2;
   localparam int SLOT_OUT_W = 2;
   localparam int COUNT_OUT_W = 3;
   localparam int MASK_W    = 4;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_TIMEOUT = CSR_ADDR_W'(0);
   localparam logic [TIME_W-1:0]     TIMEOUT_RESET    = TIME_W'(30000);

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_SWEEP    = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_REFRESH = 2'd0,
      ACT_INSERT  = 2'd1,
      ACT_EVICT   = 2'd2,
      ACT_SWEEP   = 2'd3
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the accepted transaction, restart the scan
      logic step;    // examine the slot under the scan index
      logic commit;  // write the table and load the result register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;  // the scan index points at the last slot
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/ctlru_dp.sv]
// Datapath of the client table: entry storage, slot scan, result register.
// Depends on ctlru_pkg and the assertion macro header.
`default_nettype none
`include "client_table_lru_with_aging_assert.svh"

module ctlru_dp
   import ctlru_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   output      dp_status_type          status,
   input  wire logic [TIME_W-1:0]      timeout_ms,
   input  wire logic                   req_cmd,
   input  wire logic [ADDR_W-1:0]      req_client_addr,
   input  wire logic [PORT_W-1:0]      req_client_port,
   input  wire logic [TIME_W-1:0]      req_now_ms,
   output      logic [ACTION_W-1:0]    rsp_action,
   output      logic [SLOT_OUT_W-1:0]  rsp_slot,
   output      logic [COUNT_OUT_W-1:0] rsp_active_count,
   output      logic [MASK_W-1:0]      rsp_expired_mask
);

   // Table storage. Payload words only matter behind a valid bit.
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [ADDR_W-1:0]    addr_ff [NUM_SLOTS];
   logic [PORT_W-1:0]    port_ff [NUM_SLOTS];
   logic [TIME_W-1:0]    heard_ff [NUM_SLOTS];
   logic [CNT_W-1:0]     count_ff, count_in;

   // Captured transaction.
   logic                 op_ff;
   logic [ADDR_W-1:0]    op_addr_ff;
   logic [PORT_W-1:0]    op_port_ff;
   logic [TIME_W-1:0]    op_now_ff;

   // Scan state.
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic                 hit_ff, hit_in;
   logic [SLOT_W-1:0]    hit_slot_ff, hit_slot_in;
   logic                 free_ff, free_in;
   logic [SLOT_W-1:0]    free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]    old_slot_ff, old_slot_in;
   logic [TIME_W-1:0]    old_age_ff, old_age_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;

   // Result register.
   action_type           act_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [CNT_W-1:0]     res_count_ff;
   logic [MASK_W-1:0]    res_mask_ff;

   logic [TIME_W-1:0]    age;
   logic                 match;
   logic [SLOT_W-1:0]    target;
   action_type           commit_act;

   assign age    = op_now_ff - heard_ff[idx_ff];
   assign match  = valid_ff[idx_ff] && (addr_ff[idx_ff] == op_addr_ff)
                   && (port_ff[idx_ff] == op_port_ff);
   assign status.scan_last = (idx_ff == SLOT_W'(NUM_SLOTS - 1));

   always_comb begin
      target     = old_slot_ff;
      commit_act = ACT_EVICT;
      if (op_ff == CMD_SWEEP) begin
         target     = '0;
         commit_act = ACT_SWEEP;
      end else if (hit_ff) begin
         target     = hit_slot_ff;
         commit_act = ACT_REFRESH;
      end else if (free_ff) begin
         target     = free_slot_ff;
         commit_act = ACT_INSERT;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      old_slot_in  = old_slot_ff;
      old_age_in   = old_age_ff;
      mask_in      = mask_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      if (cmd.load) begin
         idx_in      = '0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
         old_slot_in = '0;
         old_age_in  = '0;
         mask_in     = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + SLOT_W'(1);
         if (op_ff == CMD_SWEEP) begin
            if (valid_ff[idx_ff] && (age > timeout_ms)) begin
               valid_in[idx_ff] = 1'b0;
               count_in         = count_ff - CNT_W'(1);
               mask_in          = mask_ff | (MASK_W'(1) << idx_ff);
            end
         end else begin
            if (!hit_ff && match) begin
               hit_in      = 1'b1;
               hit_slot_in = idx_ff;
            end
            if (!free_ff && !valid_ff[idx_ff]) begin
               free_in      = 1'b1;
               free_slot_in = idx_ff;
            end
            // Strictly greater keeps ties on the lowest slot.
            if (age > old_age_ff) begin
               old_age_in  = age;
               old_slot_in = idx_ff;
            end
         end
      end else if (cmd.commit && (op_ff == CMD_REGISTER) && !hit_ff) begin
         valid_in[target] = 1'b1;
         if (free_ff) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      old_slot_ff  <= old_slot_in;
      old_age_ff   <= old_age_in;
      mask_ff      <= mask_in;
      if (cmd.load) begin
         op_ff      <= req_cmd;
         op_addr_ff <= req_client_addr;
         op_port_ff <= req_client_port;
         op_now_ff  <= req_now_ms;
      end
      if (cmd.commit) begin
         if (op_ff == CMD_REGISTER) begin
            heard_ff[target] <= op_now_ff;
            if (!hit_ff) begin
               addr_ff[target] <= op_addr_ff;
               port_ff[target] <= op_port_ff;
            end
         end
         act_ff       <= commit_act;
         slot_ff      <= target;
         res_count_ff <= count_in;
         res_mask_ff  <= mask_ff;
      end
   end

   assign rsp_action       = act_ff;
   assign rsp_slot         = SLOT_OUT_W'(slot_ff);
   assign rsp_active_count = COUNT_OUT_W'(res_count_ff);
   assign rsp_expired_mask = res_mask_ff;

   `CTLRU_ASSERT(a_count_tracks_valid, clock, reset, 32'(count_ff) == $countones(valid_ff))
   `CTLRU_ASSERT(a_count_bounded, clock, reset, 32'(count_ff) <= NUM_SLOTS)
   `CTLRU_ASSERT(a_step_needs_scan, clock, reset, cmd.step |-> !(cmd.load || cmd.commit))

endmodule

`default_nettype wire

[rtl/ctlru_ctrl.sv]
// Controller of the client table: sequences capture, slot scan and commit.
// Depends on ctlru_pkg and the assertion macro header.
`default_nettype none
`include "client_table_lru_with_aging_assert.svh"

module ctlru_ctrl
   import ctlru_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      dp_cmd_type    cmd,
   input  wire dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new result when empty or drained this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.step   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_COMMIT) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CTLRU_ASSERT(a_accept_starts_scan, clock, reset, cmd.load |=> (state_ff == ST_SCAN))
   `CTLRU_ASSERT(a_held_result_blocks, clock, reset, ((state_ff == ST_COMMIT) && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_COMMIT))
   `CTLRU_ASSERT(a_commit_raises_valid, clock, reset, cmd.commit |=> rsp_valid_ff)

endmodule

`default_nettype wire

[rtl/client_table_lru_with_aging.sv]
// Top level of the client table with LRU replacement and timeout aging.
// Depends on ctlru_pkg, ctlru_ctrl and ctlru_dp.
`default_nettype none

// The block keeps a table of NUM_SLOTS client endpoints (address, port,
// last-heard time). A register transaction refreshes the entry that matches
// address and port, or else takes the lowest free slot, or else replaces the
// entry with the greatest wrapping age (now minus last-heard, modulo 2^32),
// with ties going to the lowest slot. A sweep transaction drops every valid
// entry whose age exceeds timeout_ms, which sits at byte address 0 of the
// configuration port and resets to 30000. Each transaction is captured,
// then the datapath examines one slot per cycle through a single age
// subtractor, then a commit step writes the table and the result
// register. The next transaction is taken only once the commit is done,
// and then even if the previous result is still waiting on rsp_stall. The
// result register holds a finished result until it is taken, and the commit
// of the next transaction waits for it. Configuration writes are meant to
// happen only while the block is idle.

module client_table_lru_with_aging
   import ctlru_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input transaction channel.
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_cmd,
   input  wire logic [ADDR_W-1:0]      req_client_addr,
   input  wire logic [PORT_W-1:0]      req_client_port,
   input  wire logic [TIME_W-1:0]      req_now_ms,
   // Result channel.
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [ACTION_W-1:0]    rsp_action,
   output      logic [SLOT_OUT_W-1:0]  rsp_slot,
   output      logic [COUNT_OUT_W-1:0] rsp_active_count,
   output      logic [MASK_W-1:0]      rsp_expired_mask,
   // Configuration port.
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output      logic [CSR_DATA_W-1:0]  prdata,
   output      logic                   pready
);

   logic [TIME_W-1:0] timeout_ff, timeout_in;
   logic              csr_hit;
   dp_cmd_type        cmd;
   dp_status_type     status;

   // The port never inserts wait states. Only the aligned word at address 0
   // is a register; writes anywhere else are dropped and read back as zero.
   assign pready  = 1'b1;
   assign csr_hit = (paddr == CSR_ADDR_TIMEOUT);
   assign prdata  = csr_hit ? CSR_DATA_W'(timeout_ff) : '0;

   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         timeout_in = TIME_W'(pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   ctlru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ctlru_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .timeout_ms       (timeout_ff),
      .req_cmd          (req_cmd),
      .req_client_addr  (req_client_addr),
      .req_client_port  (req_client_port),
      .req_now_ms       (req_now_ms),
      .rsp_action       (rsp_action),
      .rsp_slot         (rsp_slot),
      .rsp_active_count (rsp_active_count),
      .rsp_expired_mask (rsp_expired_mask)
   );

endmodule

`default_nettype wire
